### hw/rtl/universal_hash_mod_prime_assert.svh
// Assertion macros shared by the universal hash RTL.
`ifndef UNIVERSAL_HASH_MOD_PRIME_ASSERT_SVH
`define UNIVERSAL_HASH_MOD_PRIME_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define UHMP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define UHMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/uhmp_pkg.sv
// Package with the constants and field layout of the universal hash block.
package uhmp_pkg;

    localparam int          MAX_KEY_LEN = 256;
    localparam int          ADDR_W      = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int          POS_W       = $clog2(MAX_KEY_LEN + 1);
    localparam logic [31:0] HASH_PRIME  = 32'hFFFF_FFFB;

    localparam int IDX_W   = 8;
    localparam int COEF_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int HASH_W  = 32;
    localparam int PROD_W  = COEF_W + BYTE_W;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    localparam int IDX_LSB  = 0;
    localparam int COEF_LSB = IDX_LSB + IDX_W;
    localparam int BYTE_LSB = COEF_LSB + COEF_W;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_HASH = 1'b1;

    // Reduces a value below twice the prime by one conditional subtraction.
    function automatic logic [31:0] reduce_once(input logic [32:0] val);
        logic [32:0] diff;
        diff = val - {1'b0, HASH_PRIME};
        reduce_once = (val >= {1'b0, HASH_PRIME}) ? diff[31:0] : val[31:0];
    endfunction

endpackage

### hw/rtl/universal_hash_mod_prime.sv
// Top level of the Carter-Wegman universal hash modulo the prime 2^32 - 5.
//
// One input stream carries two kinds of request, chosen by the tuser bit.
// A load request writes one coefficient word into the 256-entry table at the
// given index, reduced below the prime. A hash request carries one key byte;
// tlast marks the final byte of a key. Each key byte is multiplied by the
// coefficient at its position and summed modulo the prime. On the final byte
// the output stream gives the hash and a too_long flag, set when the key had
// more bytes than the table; those extra bytes do not enter the hash.
// Requests are taken one per clock while the input is not stalled. A result
// is registered in stages: the table read happens at the accepting edge, then
// multiply, modular fold and accumulate take one register stage each.
// The accumulate register closes the only per-byte loop, one add and compare.
// A waiting result does not stop the input; it stalls only when a second
// result reaches the accumulate stage while the output register is still full.
// Reset clears the position, the accumulator, the overflow flag and all valid
// bits; the coefficient table is not cleared and must be loaded before use.
module universal_hash_mod_prime (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // coef_index, coef_value, data_byte from bit 0 up.
    input  logic [uhmp_pkg::IN_DATA_W-1:0] i_s_tdata,
    // action.
    input  logic [0:0]                     i_s_tuser,
    // last_byte.
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // hash_value.
    output logic [uhmp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // too_long.
    output logic [0:0]                     o_m_tuser
);

    import uhmp_pkg::*;

    typedef struct packed {
        logic last;
        logic inr;
        logic tl;
    } t_ctl;

    logic [IDX_W-1:0]  in_idx;
    logic [COEF_W-1:0] in_coef;
    logic [BYTE_W-1:0] in_byte;
    logic              adv;
    logic              hs;
    logic              load_req;
    logic              hash_req;
    logic              load_we;
    logic [COEF_W-1:0] load_val;
    logic              pos_inr;
    logic [COEF_W-1:0] ram_rdata;

    logic [POS_W-1:0]  r_pos;
    logic              r_ovf;

    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    t_ctl              r_s1_ctl;
    logic              r_s2_valid;
    logic [PROD_W-1:0] r_s2_prod;
    t_ctl              r_s2_ctl;
    logic              r_s3_valid;
    logic [HASH_W-1:0] r_s3_term;
    t_ctl              r_s3_ctl;

    logic [HASH_W-1:0] r_acc;
    logic [HASH_W-1:0] n_acc;
    logic [32:0]       fold_sum;
    logic [HASH_W-1:0] fold_term;
    logic [HASH_W-1:0] add_term;

    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_hash;
    logic              r_out_tl;

    assign in_idx  = i_s_tdata[IDX_LSB +: IDX_W];
    assign in_coef = i_s_tdata[COEF_LSB +: COEF_W];
    assign in_byte = i_s_tdata[BYTE_LSB +: BYTE_W];

    assign adv      = !(r_s3_valid && r_s3_ctl.last && r_out_valid && !i_m_tready);
    assign hs       = i_s_tvalid && adv;
    assign load_req = hs && (i_s_tuser[0] == ACT_LOAD);
    assign hash_req = hs && (i_s_tuser[0] == ACT_HASH);
    assign load_we  = load_req && (int'(in_idx) < MAX_KEY_LEN);
    assign load_val = reduce_once({1'b0, in_coef});
    assign pos_inr  = r_pos < POS_W'(MAX_KEY_LEN);

    uhmp_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_KEY_LEN)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (ADDR_W'(in_idx)),
        .i_wdata (load_val),
        .i_re    (hash_req),
        .i_raddr (ADDR_W'(r_pos)),
        .o_rdata (ram_rdata)
    );

    // Position and overflow tracking at acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ovf <= 1'b0;
        end else if (hash_req) begin
            if (i_s_tlast) begin
                r_pos <= '0;
                r_ovf <= 1'b0;
            end else if (pos_inr) begin
                r_pos <= r_pos + POS_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // The high bits fold back in times 5, since 2^32 is 5 modulo the prime.
    assign fold_sum  = {1'b0, r_s2_prod[31:0]}
                     + 33'({r_s2_prod[PROD_W-1:32], 2'b00})
                     + 33'(r_s2_prod[PROD_W-1:32]);
    assign fold_term = reduce_once(fold_sum);
    assign add_term  = r_s3_ctl.inr ? r_s3_term : '0;
    assign n_acc     = reduce_once({1'b0, r_acc} + {1'b0, add_term});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= hash_req;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_byte     <= in_byte;
            r_s1_ctl.last <= i_s_tlast;
            r_s1_ctl.inr  <= pos_inr;
            r_s1_ctl.tl   <= r_ovf || !pos_inr;
            r_s2_prod     <= ram_rdata * r_s1_byte;
            r_s2_ctl      <= r_s1_ctl;
            r_s3_term     <= fold_term;
            r_s3_ctl      <= r_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (adv && r_s3_valid) begin
                if (r_s3_ctl.last) begin
                    r_acc       <= '0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_acc <= n_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s3_valid && r_s3_ctl.last) begin
            r_out_hash <= n_acc;
            r_out_tl   <= r_s3_ctl.tl;
        end
    end

    assign o_s_tready = adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_hash;
    assign o_m_tuser  = r_out_tl;

    `include "universal_hash_mod_prime_assert.svh"

    `UHMP_ASSERT_SAME(a_pos_bound, 1'b1, r_pos <= POS_W'(MAX_KEY_LEN),
        "Byte position ran past the table length.")
    `UHMP_ASSERT_SAME(a_acc_reduced, 1'b1, r_acc < HASH_PRIME,
        "Accumulator is not reduced below the prime.")
    `UHMP_ASSERT_SAME(a_term_reduced, r_s3_valid, r_s3_term < HASH_PRIME,
        "Folded term is not reduced below the prime.")
    `UHMP_ASSERT_NEXT(a_acc_cleared, adv && r_s3_valid && r_s3_ctl.last,
        r_acc == '0 && r_out_valid,
        "Final byte did not clear the accumulator and post a result.")

endmodule

### hw/rtl/uhmp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module uhmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
